>>> rtl/assert_macros.svh
// Assertion macros for the timestamp converter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr, msg)
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif
`endif

>>> rtl/iso2ep_pkg.sv
// Types, constants and tables shared by the timestamp converter
package iso2ep_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_Z     = 8'h5A;

  localparam int NUM_FIELDS = 5;
  localparam int EPOCH_W    = 39;
  localparam int DAY_SHIFT  = 7;

  localparam logic [8:0]  YEAR_BIAS          = 9'd400;
  localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
  localparam logic [17:0] DAYS_PER_ERA       = 18'd146097;
  localparam logic [19:0] DAYS_EPOCH_OFFSET  = 20'd865565;
  localparam logic [11:0] SECS_PER_HOUR      = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN       = 6'd60;
  localparam logic [9:0]  DAY_SCALE          = 10'd675;
  localparam logic [7:0]  MONTH_RECIP        = 8'd171;
  localparam longint      EPOCH_MAX          = 64'sd274877906943;
  localparam longint      EPOCH_MIN          = -64'sd274877906944;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PARSE = 2'd1,
    ST_CONV  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PS_YEAR,
    PS_FIELD,
    PS_DONE
  } ps_state_t;

  typedef enum logic [1:0] {
    PT_TENS,
    PT_UNITS,
    PT_SEP
  } part_t;

  typedef enum logic [2:0] {
    CV_IDLE,
    CV_PREP,
    CV_DIV,
    CV_REM,
    CV_DOE,
    CV_DAYS,
    CV_SECS,
    CV_FIN
  } cv_state_t;

  typedef struct packed {
    logic       perr;
    logic [6:0] month;
    logic [6:0] day;
    logic [6:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
  } job_flds_t;

  function automatic logic [7:0] sep_char(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0:    c = CH_DASH;
      3'd1:    c = CH_T;
      3'd2:    c = CH_COLON;
      3'd3:    c = CH_COLON;
      3'd4:    c = CH_Z;
      default: c = CH_Z;
    endcase
    return c;
  endfunction

  // day of a March-based year on which month m (0 = January) starts
  function automatic logic [8:0] doy_of_month(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd306;
      4'd1:    d = 9'd337;
      4'd2:    d = 9'd0;
      4'd3:    d = 9'd31;
      4'd4:    d = 9'd61;
      4'd5:    d = 9'd92;
      4'd6:    d = 9'd122;
      4'd7:    d = 9'd153;
      4'd8:    d = 9'd184;
      4'd9:    d = 9'd214;
      4'd10:   d = 9'd245;
      4'd11:   d = 9'd275;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/iso2ep_parse.sv
// Front end: character parser that builds one conversion job per string
`include "assert_macros.svh"
module iso2ep_parse import iso2ep_pkg::*; #(
  parameter int YEAR_DIGITS = 4,
  parameter int YEAR_W      = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        character,
  input  logic              last_char,
  input  logic              accept,
  output logic              job_push,
  output logic [YEAR_W-1:0] job_year,
  output job_flds_t         job_flds
);

  localparam int YDC_W = $clog2(YEAR_DIGITS + 1);

  ps_state_t         st_r, st_nxt, st_c;
  part_t             part_r, part_nxt, part_c;
  logic [2:0]        k_r, k_nxt, k_c;
  logic [YEAR_W-1:0] year_r, year_nxt, year_c;
  logic [YDC_W-1:0]  ydc_r, ydc_nxt, ydc_c;
  logic              err_r, err_nxt, err_c;
  logic [6:0]        fld_r [NUM_FIELDS];
  logic              fld_we;
  logic [6:0]        fld_wdata;
  logic              digit;
  logic [3:0]        dval;
  logic [YEAR_W+3:0] year_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= PS_YEAR;
      part_r <= PT_TENS;
      k_r    <= '0;
      year_r <= '0;
      ydc_r  <= '0;
      err_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      part_r <= part_nxt;
      k_r    <= k_nxt;
      year_r <= year_nxt;
      ydc_r  <= ydc_nxt;
      err_r  <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fld_we) begin
      fld_r[k_r] <= fld_wdata;
    end
  end

  always_comb begin
    digit     = character inside {[CH_ZERO:CH_NINE]};
    dval      = character[3:0];
    year_x    = (YEAR_W+4)'({year_r, 3'b000}) + (YEAR_W+4)'({year_r, 1'b0})
              + (YEAR_W+4)'(dval);
    st_c      = st_r;
    part_c    = part_r;
    k_c       = k_r;
    year_c    = year_r;
    ydc_c     = ydc_r;
    err_c     = err_r;
    fld_we    = 1'b0;
    fld_wdata = 7'({dval, 3'b000}) + 7'({dval, 1'b0});
    if (!err_r) begin
      case (st_r)
        PS_YEAR: begin
          if (digit) begin
            if (ydc_r < YDC_W'(YEAR_DIGITS)) begin
              year_c = year_x[YEAR_W-1:0];
              ydc_c  = ydc_r + 1'b1;
            end else begin
              err_c = 1'b1;
            end
          end else if (character == CH_DASH && ydc_r != '0) begin
            st_c   = PS_FIELD;
            k_c    = '0;
            part_c = PT_TENS;
          end else begin
            err_c = 1'b1;
          end
        end
        PS_FIELD: begin
          case (part_r)
            PT_TENS: begin
              if (digit) begin
                fld_we = accept;
                part_c = PT_UNITS;
              end else begin
                err_c = 1'b1;
              end
            end
            PT_UNITS: begin
              if (digit) begin
                fld_we    = accept;
                fld_wdata = fld_r[k_r] + 7'(dval);
                part_c    = PT_SEP;
              end else begin
                err_c = 1'b1;
              end
            end
            PT_SEP: begin
              if (character == sep_char(k_r)) begin
                if (k_r == 3'(NUM_FIELDS - 1)) begin
                  st_c = PS_DONE;
                end else begin
                  k_c    = k_r + 3'd1;
                  part_c = PT_TENS;
                end
              end else begin
                err_c = 1'b1;
              end
            end
            default: err_c = 1'b1;
          endcase
        end
        PS_DONE: err_c = 1'b1;
        default: err_c = 1'b1;
      endcase
    end

    job_push        = accept && last_char;
    job_year        = year_r;
    job_flds.perr   = err_c || (st_c != PS_DONE);
    job_flds.month  = fld_r[0];
    job_flds.day    = fld_r[1];
    job_flds.hour   = fld_r[2];
    job_flds.minute = fld_r[3];
    job_flds.second = fld_r[4];

    st_nxt   = st_r;
    part_nxt = part_r;
    k_nxt    = k_r;
    year_nxt = year_r;
    ydc_nxt  = ydc_r;
    err_nxt  = err_r;
    if (accept) begin
      if (last_char) begin
        st_nxt   = PS_YEAR;
        part_nxt = PT_TENS;
        k_nxt    = '0;
        year_nxt = '0;
        ydc_nxt  = '0;
        err_nxt  = 1'b0;
      end else begin
        st_nxt   = st_c;
        part_nxt = part_c;
        k_nxt    = k_c;
        year_nxt = year_c;
        ydc_nxt  = ydc_c;
        err_nxt  = err_c;
      end
    end
  end

  `ASSERT_NEXT(a_err_sticky, clk, rst_n, err_r && accept && !last_char, err_r, "parse error cleared mid-string")
  `ASSERT_ALWAYS(a_ydc_range, clk, rst_n, ydc_r <= YDC_W'(YEAR_DIGITS), "year digit count too large")

endmodule

>>> rtl/iso2ep_fifo.sv
// Job queue between the parser and the converter
`include "assert_macros.svh"
module iso2ep_fifo #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(DEPTH), "queue count beyond depth")
  `ASSERT_NEXT(a_push_fills, clk, rst_n, do_wr, cnt_r != '0, "queue empty after a write")

endmodule

>>> rtl/iso2ep_conv.sv
// Back end: sequenced calendar-to-seconds conversion and result register
`include "assert_macros.svh"
module iso2ep_conv import iso2ep_pkg::*; #(
  parameter int YEAR_W = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  logic [YEAR_W-1:0]  job_year,
  input  job_flds_t          job_flds,
  output logic               job_pop,
  input  logic               pop,
  output logic               empty,
  output logic [EPOCH_W-1:0] epoch_seconds,
  output status_t            status
);

  localparam int YY_W      = ((YEAR_W > 9) ? YEAR_W : 9) + 1;
  localparam int ERA_W     = YY_W - 8;
  localparam int DAYS_W    = ERA_W + 19;
  localparam int T_W       = DAYS_W + 18;
  localparam int CMP_W     = T_W + 1;
  localparam int RCP_SHIFT = YY_W + $clog2(YEAR_BIAS);
  localparam int QP_W      = 2 * YY_W + 1;
  localparam logic [YY_W:0] ERA_RECIP =
    (YY_W+1)'(((64'd1 << RCP_SHIFT) + 64'(YEAR_BIAS) - 64'd1) / 64'(YEAR_BIAS));

  cv_state_t          st_r, st_nxt;
  logic [3:0]         m_r, m_nxt;
  logic [YY_W-1:0]    dq_r, dq_nxt;
  logic [ERA_W-1:0]   era_r, era_nxt;
  logic [8:0]         rem_r, rem_nxt;
  logic [17:0]        doe_r, doe_nxt;
  logic [18:0]        hms_r, hms_nxt;
  logic [DAYS_W-1:0]  days_r, days_nxt;
  logic [T_W-1:0]     t_r, t_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [EPOCH_W-1:0] out_epoch_r, out_epoch_nxt;
  status_t            out_status_r, out_status_nxt;

  logic [6:0]         mon0, r7;
  logic [14:0]        q_full;
  logic [3:0]         q, r;
  logic [YY_W-1:0]    yy;
  logic [3:0]         m_sel;
  logic [QP_W-1:0]    quot_prod;
  logic [1:0]         c100;
  logic [ERA_W+17:0]  era_prod;
  logic [T_W-1:0]     dext;
  logic signed [CMP_W-1:0] tsx;
  logic               conv_bad;
  status_t            res_status;

  assign empty         = !out_valid_r;
  assign epoch_seconds = out_epoch_r;
  assign status        = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= CV_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r          <= m_nxt;
    dq_r         <= dq_nxt;
    era_r        <= era_nxt;
    rem_r        <= rem_nxt;
    doe_r        <= doe_nxt;
    hms_r        <= hms_nxt;
    days_r       <= days_nxt;
    t_r          <= t_nxt;
    out_epoch_r  <= out_epoch_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    mon0     = job_flds.month - 7'd1;
    q_full   = 15'(mon0) * 15'(MONTH_RECIP);
    q        = q_full[14:11];
    r7       = mon0 - {q, 3'b000} - 7'({q, 2'b00});
    r        = r7[3:0];
    if (job_flds.month == 7'd0) begin
      m_sel = 4'd11;
      yy    = YY_W'(job_year) + YY_W'(YEAR_BIAS) - YY_W'(1);
    end else begin
      m_sel = r;
      yy    = YY_W'(job_year) + YY_W'(q) + YY_W'(YEAR_BIAS) - YY_W'(r < 4'd2);
    end

    quot_prod = QP_W'(dq_r) * QP_W'(ERA_RECIP);
    c100     = 2'(rem_r >= 9'd100) + 2'(rem_r >= 9'd200) + 2'(rem_r >= 9'd300);
    era_prod = (ERA_W+18)'(era_r) * (ERA_W+18)'(DAYS_PER_ERA);
    dext     = {{(T_W-DAYS_W){days_r[DAYS_W-1]}}, days_r};

    tsx      = CMP_W'($signed(t_r));
    conv_bad = (t_r == '1) || (tsx > CMP_W'(EPOCH_MAX)) || (tsx < CMP_W'(EPOCH_MIN));
    if (job_flds.perr) begin
      res_status = ST_PARSE;
    end else if (conv_bad) begin
      res_status = ST_CONV;
    end else begin
      res_status = ST_OK;
    end

    st_nxt         = st_r;
    m_nxt          = m_r;
    dq_nxt         = dq_r;
    era_nxt        = era_r;
    rem_nxt        = rem_r;
    doe_nxt        = doe_r;
    hms_nxt        = hms_r;
    days_nxt       = days_r;
    t_nxt          = t_r;
    out_valid_nxt  = out_valid_r && !pop;
    out_epoch_nxt  = out_epoch_r;
    out_status_nxt = out_status_r;
    job_pop        = 1'b0;

    case (st_r)
      CV_IDLE: begin
        if (job_valid) begin
          st_nxt = CV_PREP;
        end
      end
      CV_PREP: begin
        m_nxt   = m_sel;
        dq_nxt  = yy;
        rem_nxt = '0;
        hms_nxt = 19'(job_flds.hour) * 19'(SECS_PER_HOUR)
                + 19'(job_flds.minute) * 19'(SECS_PER_MIN) + 19'(job_flds.second);
        st_nxt  = job_flds.perr ? CV_FIN : CV_DIV;
      end
      CV_DIV: begin
        era_nxt = quot_prod[RCP_SHIFT +: ERA_W];
        st_nxt  = CV_REM;
      end
      CV_REM: begin
        rem_nxt = 9'(10'(dq_r) - 10'({era_r, 8'b0}) - 10'({era_r, 7'b0})
                - 10'({era_r, 4'b0}));
        st_nxt  = CV_DOE;
      end
      CV_DOE: begin
        doe_nxt = 18'(rem_r) * 18'(DAYS_PER_YEAR) + 18'(rem_r[8:2]) - 18'(c100)
                + 18'(doy_of_month(m_r));
        st_nxt  = CV_DAYS;
      end
      CV_DAYS: begin
        days_nxt = DAYS_W'(era_prod) + DAYS_W'(doe_r) + DAYS_W'(job_flds.day)
                 - DAYS_W'(1) - DAYS_W'(DAYS_EPOCH_OFFSET);
        st_nxt   = CV_SECS;
      end
      CV_SECS: begin
        t_nxt  = ((dext * T_W'(DAY_SCALE)) << DAY_SHIFT) + T_W'(hms_r);
        st_nxt = CV_FIN;
      end
      CV_FIN: begin
        if (!out_valid_r || pop) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status;
          out_epoch_nxt  = (res_status == ST_OK) ? t_r[EPOCH_W-1:0] : '0;
          job_pop        = 1'b1;
          st_nxt         = CV_IDLE;
        end
      end
      default: st_nxt = CV_IDLE;
    endcase
  end

  `ASSERT_ALWAYS(a_err_zero, clk, rst_n, !out_valid_r || out_status_r == ST_OK || out_epoch_r == '0, "error result with nonzero seconds")

endmodule

>>> rtl/iso8601_utc_to_epoch_seconds.sv
// Top level: streaming ISO 8601 UTC timestamp to Unix seconds converter
// Usage:
//   Input queue port: one timestamp character per transaction on in_character,
//   with in_last_char set on the final one; a transaction completes when push
//   is high and full is low. Characters are taken one per cycle unless full.
//   Result queue port: one result per string (seconds and status) is shown
//   while empty is low and leaves on a cycle with pop high.
// Conversion: after a well-formed string's last character is taken, its job
//   passes through the queue, operand set-up, divide by 400 years by
//   reciprocal multiply, year-of-era remainder, day-of-era, day count,
//   seconds, then the result register. A malformed string skips the
//   arithmetic and goes from operand set-up to the result register.
// Queueing: the converter takes the next string only once the last one's
//   result is registered; a queue of JOB_DEPTH parsed strings absorbs short
//   strings in a row.
// Reset: rst_n low for one cycle empties both queues and restarts parsing.
// Stall: while the result is not popped the converter holds its next result,
//   the job queue fills and full rises; nothing is dropped.
module iso8601_utc_to_epoch_seconds import iso2ep_pkg::*; #(
  parameter int YEAR_DIGITS = 4,
  parameter int JOB_DEPTH   = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [7:0]                in_character,
  input  logic                      in_last_char,
  input  logic                      push,
  output logic                      full,
  output logic signed [EPOCH_W-1:0] out_epoch_seconds,
  output logic [1:0]                out_status,
  output logic                      empty,
  input  logic                      pop
);

  localparam int YEAR_W = $clog2(10 ** YEAR_DIGITS);
  localparam int FLD_W  = $bits(job_flds_t);
  localparam int JOB_W  = YEAR_W + FLD_W;

  logic              accept;
  logic              job_push;
  logic [YEAR_W-1:0] job_year;
  job_flds_t         job_flds;
  logic [JOB_W-1:0]  q_dout;
  logic              q_empty;
  logic              q_pop;
  logic [YEAR_W-1:0] q_year;
  job_flds_t         q_flds;
  logic [EPOCH_W-1:0] conv_epoch;
  status_t           conv_status;

  assign accept = push && !full;

  iso2ep_parse #(
    .YEAR_DIGITS (YEAR_DIGITS),
    .YEAR_W      (YEAR_W)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .character (in_character),
    .last_char (in_last_char),
    .accept    (accept),
    .job_push  (job_push),
    .job_year  (job_year),
    .job_flds  (job_flds)
  );

  iso2ep_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   ({job_year, job_flds}),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign q_year = q_dout[JOB_W-1 -: YEAR_W];
  assign q_flds = q_dout[FLD_W-1:0];

  iso2ep_conv #(
    .YEAR_W (YEAR_W)
  ) u_conv (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (!q_empty),
    .job_year      (q_year),
    .job_flds      (q_flds),
    .job_pop       (q_pop),
    .pop           (pop),
    .empty         (empty),
    .epoch_seconds (conv_epoch),
    .status        (conv_status)
  );

  assign out_epoch_seconds = conv_epoch;
  assign out_status        = conv_status;

endmodule

>>> verif/tb_iso8601_utc_to_epoch_seconds.sv
// Testbench for the streaming ISO 8601 timestamp to epoch seconds converter
module tb_iso8601_utc_to_epoch_seconds import iso2ep_pkg::*; ();

  localparam int YEAR_DIGITS = 4;
  localparam int PHASE_DONE  = 16;
  localparam int ITEM_GOAL   = 1550;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 40;
  localparam int LIMIT       = 600000;

  typedef struct packed {
    logic signed [EPOCH_W-1:0] secs;
    status_t                   st;
  } stamp_res_t;

  typedef struct {
    string   txt;
    bit      pinned;
    longint  secs;
    status_t st;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic [7:0]                in_character = '0;
  logic                      in_last_char = 1'b0;
  logic                      push = 1'b0;
  logic                      full;
  logic signed [EPOCH_W-1:0] out_epoch_seconds;
  logic [1:0]                out_status;
  logic                      empty;
  logic                      pop = 1'b0;

  stamp_res_t  due_q[$];
  bit [7:0]    char_q[$];
  int          faults = 0;
  int          cycle_cnt = 0;
  bit          calm = 1'b0;
  bit          hold_off_req = 1'b0;

  int unsigned p_phase = 0;
  int unsigned yr_val = 0;
  int unsigned yr_cnt = 0;
  int unsigned fld[NUM_FIELDS] = '{default: 0};
  bit          p_err = 1'b0;

  iso8601_utc_to_epoch_seconds i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_character      (in_character),
    .in_last_char      (in_last_char),
    .push              (push),
    .full              (full),
    .out_epoch_seconds (out_epoch_seconds),
    .out_status        (out_status),
    .empty             (empty),
    .pop               (pop)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic flag_fault(input string what);
    faults++;
    if (faults <= 10) $display("%s", what);
  endtask

  function automatic bit predict_char(input bit [7:0] ch, input bit last,
                                      output stamp_res_t res);
    bit [7:0] sep_tab[NUM_FIELDS];
    bit       digit;
    int       dv;
    int       k;
    part_t    part;
    longint   y, m, yy, era, yoe, mp, doy, doe, days, t;
    sep_tab = '{CH_DASH, CH_T, CH_COLON, CH_COLON, CH_Z};
    digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    dv = int'(ch) - int'(CH_ZERO);
    res = '0;
    if (!p_err) begin
      if (p_phase == 0) begin
        if (digit) begin
          if (yr_cnt < YEAR_DIGITS) begin
            yr_val = yr_val * 10 + dv;
            yr_cnt++;
          end else begin
            p_err = 1'b1;
          end
        end else if (ch == CH_DASH && yr_cnt > 0) begin
          p_phase = 1;
        end else begin
          p_err = 1'b1;
        end
      end else if (p_phase >= PHASE_DONE) begin
        p_err = 1'b1;
      end else begin
        k = (p_phase - 1) / 3;
        part = part_t'((p_phase - 1) % 3);
        case (part)
          PT_TENS: begin
            if (digit) fld[k] = 10 * dv;
            else p_err = 1'b1;
          end
          PT_UNITS: begin
            if (digit) fld[k] = fld[k] + dv;
            else p_err = 1'b1;
          end
          default: begin
            if (ch != sep_tab[k]) p_err = 1'b1;
          end
        endcase
        if (!p_err) p_phase++;
      end
    end
    if (!last) return 1'b0;
    if (p_err || p_phase != PHASE_DONE) begin
      res.st = ST_PARSE;
    end else begin
      y = longint'(yr_val);
      if (fld[0] == 0) begin
        y = y - 1;
        m = 12;
      end else begin
        y = y + (longint'(fld[0]) - 1) / 12;
        m = (longint'(fld[0]) - 1) % 12 + 1;
      end
      yy = y + 400 - ((m < 3) ? 1 : 0);
      era = yy / 400;
      yoe = yy - era * 400;
      mp = (m + 9) % 12;
      doy = (153 * mp + 2) / 5;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * 146097 + doe - 719468 - 146097 + longint'(fld[1]) - 1;
      t = days * 86400 + longint'(fld[2]) * 3600 + longint'(fld[3]) * 60
          + longint'(fld[4]);
      if (t == -1 || t < EPOCH_MIN || t > EPOCH_MAX) begin
        res.st = ST_CONV;
      end else begin
        res.st = ST_OK;
        res.secs = t[EPOCH_W-1:0];
      end
    end
    p_phase = 0;
    yr_val = 0;
    yr_cnt = 0;
    fld = '{default: 0};
    p_err = 1'b0;
    return 1'b1;
  endfunction

  task automatic build_stamp(input int yr_digits);
    string s;
    int    fv[NUM_FIELDS];
    int    fmin[NUM_FIELDS];
    int    fmax[NUM_FIELDS];
    fmin = '{1, 1, 0, 0, 0};
    fmax = '{12, 31, 23, 59, 59};
    s = "";
    if ($urandom_range(11) == 0) begin
      s = $urandom_range(1) ? "1969" : "1970";
      case ($urandom_range(2))
        0:       fv = '{12, 31, 23, 59, 59};
        1:       fv = '{1, 0, 23, 59, 59};
        default: fv = '{1, 1, 0, 0, $urandom_range(1)};
      endcase
    end else begin
      repeat (yr_digits) s = {s, $sformatf("%0d", $urandom_range(9))};
      foreach (fv[i]) begin
        if ($urandom_range(3) == 0) fv[i] = $urandom_range(99);
        else fv[i] = $urandom_range(fmax[i], fmin[i]);
      end
    end
    s = {s, $sformatf("-%02d-%02dT%02d:%02d:%02dZ", fv[0], fv[1], fv[2], fv[3], fv[4])};
    char_q.delete();
    for (int i = 0; i < s.len(); i++) char_q.push_back(s[i]);
  endtask

  task automatic send_bytes(input bit pinned, input longint psecs, input status_t pst);
    stamp_res_t res;
    bit [7:0]   ch;
    bit         last;
    for (int i = 0; i < char_q.size(); i++) begin
      ch = char_q[i];
      last = (i == char_q.size() - 1);
      if (!calm && $urandom_range(7) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(14, 1)) @(posedge clk);
      end
      push <= 1'b1;
      in_character <= ch;
      in_last_char <= last;
      do @(posedge clk); while (full);
      if (predict_char(ch, last, res)) begin
        if (pinned) begin
          res.secs = psecs[EPOCH_W-1:0];
          res.st = pst;
        end
        due_q.push_back(res);
      end
    end
  endtask

  // result check
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (due_q.size() == 0) begin
        flag_fault($sformatf("unexpected transaction: %0d status %0d",
                             out_epoch_seconds, out_status));
      end else begin
        if (out_epoch_seconds !== due_q[0].secs || out_status !== due_q[0].st)
          flag_fault($sformatf("mismatch: expected %0d status %0d, got %0d status %0d",
                               due_q[0].secs, due_q[0].st, out_epoch_seconds,
                               out_status));
        void'(due_q.pop_front());
      end
    end
  end

  // receiver
  initial begin
    int hold_cnt;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        pop <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(posedge clk);
          hold_cnt++;
        end
        hold_off_req = 1'b0;
        pop <= 1'b1;
      end else if (!calm && $urandom_range(7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(14, 1)) @(posedge clk);
        pop <= 1'b1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // timeout
  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    dir_row_t dir_rows[14];
    int       sent_chars;
    int       kind;
    bit       hold_done;
    bit       drain_done;
    dir_rows = '{
      '{"1970-01-01T00:00:00Z",  1'b1, 0,     ST_OK},
      '{"1970-01-02T00:00:00Z",  1'b1, 86400, ST_OK},
      '{"1969-12-31T23:59:59Z",  1'b1, 0,     ST_CONV},
      '{"1970-01-00T23:59:59Z",  1'b1, 0,     ST_CONV},
      '{"9999-99-99T99:99:99Z",  1'b0, 0,     ST_OK},
      '{"0-00-00T00:00:00Z",     1'b0, 0,     ST_OK},
      '{"0000-01-01T00:00:00Z",  1'b0, 0,     ST_OK},
      '{"2000-02-29T12:34:56Z",  1'b0, 0,     ST_OK},
      '{"-01-01T00:00:00Z",      1'b1, 0,     ST_PARSE},
      '{"12345-01-01T00:00:00Z", 1'b1, 0,     ST_PARSE},
      '{"2024-01-01T00:00",      1'b1, 0,     ST_PARSE},
      '{"2024-01-01T00:00:00ZZ", 1'b1, 0,     ST_PARSE},
      '{"2024-01-01 00:00:00Z",  1'b1, 0,     ST_PARSE},
      '{"Z",                     1'b1, 0,     ST_PARSE}
    };
    sent_chars = 0;
    hold_done = 1'b0;
    drain_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      char_q.delete();
      for (int i = 0; i < dir_rows[r].txt.len(); i++) char_q.push_back(dir_rows[r].txt[i]);
      sent_chars += char_q.size();
      send_bytes(dir_rows[r].pinned, dir_rows[r].secs, dir_rows[r].st);
    end

    while (sent_chars < ITEM_GOAL) begin
      if (sent_chars > ITEM_GOAL * 85 / 100) calm = 1'b1;
      if (!hold_done && sent_chars > ITEM_GOAL / 3) begin
        hold_off_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && sent_chars > ITEM_GOAL * 2 / 3) begin
        push <= 1'b0;
        @(posedge clk);
        wait (due_q.size() == 0);
        drain_done = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 94) build_stamp(($urandom_range(4) == 0) ? $urandom_range(3, 1) : 4);
      if (kind >= 70 && kind < 78) begin
        char_q[$urandom_range(char_q.size() - 1)] = 8'($urandom_range(255));
      end else if (kind >= 78 && kind < 84) begin
        repeat ($urandom_range(char_q.size() - 1, 1)) void'(char_q.pop_back());
      end else if (kind >= 84 && kind < 90) begin
        repeat ($urandom_range(3, 1)) char_q.push_back(8'($urandom_range(255)));
      end else if (kind >= 90 && kind < 94) begin
        repeat ($urandom_range(2, 1)) char_q.push_front(8'(CH_ZERO + $urandom_range(9)));
      end else if (kind >= 94) begin
        char_q.delete();
        repeat ($urandom_range(6, 1)) char_q.push_back(8'($urandom_range(255)));
      end
      sent_chars += char_q.size();
      send_bytes(1'b0, 0, ST_OK);
    end

    push <= 1'b0;
    @(posedge clk);
    wait (due_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (due_q.size() != 0)
      flag_fault($sformatf("%0d transactions never arrived", due_q.size()));
    if (faults == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/iso2ep_pkg.sv
rtl/iso2ep_parse.sv
rtl/iso2ep_fifo.sv
rtl/iso2ep_conv.sv
rtl/iso8601_utc_to_epoch_seconds.sv
verif/tb_iso8601_utc_to_epoch_seconds.sv
